@@ rtl/bankers_deadlock_avoidance_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Banker's allocator
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BANKERS_DEADLOCK_AVOIDANCE_DEFINES_SVH
`define BANKERS_DEADLOCK_AVOIDANCE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BDA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bda_pkg.sv @@
// ----------------------------------------------------------------------------
// bda_pkg
// Sizes, codes and controller/datapath interface types for the allocator.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int PROCESS_COUNT  = 16;
  localparam int RESOURCE_COUNT = 8;
  localparam int UNIT_WIDTH     = 8;

  localparam int PROC_W = $clog2(PROCESS_COUNT);
  localparam int RES_W  = $clog2(RESOURCE_COUNT);
  localparam int PCNT_W = $clog2(PROCESS_COUNT + 1);
  localparam int RCNT_W = $clog2(RESOURCE_COUNT + 1);
  localparam int ROW_W  = RESOURCE_COUNT * UNIT_WIDTH;
  // one RAM row per process: {max claim, allocation, need}
  localparam int RAM_W  = 3 * ROW_W;

  localparam int CFG_P_W = 5;
  localparam int CFG_R_W = 4;

  localparam logic [1:0] OP_LOAD_AVAIL = 2'd0;
  localparam logic [1:0] OP_LOAD_CLAIM = 2'd1;
  localparam logic [1:0] OP_REQUEST    = 2'd2;
  localparam logic [1:0] OP_RELEASE    = 2'd3;

  localparam logic [2:0] ST_GRANTED = 3'd0;
  localparam logic [2:0] ST_NEED    = 3'd1;
  localparam logic [2:0] ST_UNAVAIL = 3'd2;
  localparam logic [2:0] ST_UNSAFE  = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  localparam logic CFG_IDX_PROC = 1'b0;
  localparam logic CFG_IDX_RES  = 1'b1;

  typedef struct packed {
    logic       cap;        // latch accepted item
    logic       sel_walk;   // RAM read address from walk pointer
    logic       wr_claim;
    logic       wr_grant;
    logic       wr_rollback;
    logic       wr_release;
    logic       walk_init;
    logic       walk_eval;
    logic       clr_pend;
    logic       set_st;
    logic [2:0] st;
    logic       load_out;
  } bda_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       proc_ok;
    logic       chk_fail;
    logic [2:0] chk_st;
    logic       walk_last;
    logic       all_done;
    logic       progress;
  } bda_sts_t;

endpackage

@@ rtl/bankers_deadlock_avoidance.sv @@
// ----------------------------------------------------------------------------
// bankers_deadlock_avoidance
// Banker's-algorithm resource allocator with safety walk and rollback.
// ----------------------------------------------------------------------------
// Each accepted item is handled to completion before the next is taken; a
// finished result sits in the output register while the next item is
// accepted. Load-available goes through dispatch and the final state; claim
// load and release in range also write the process row. A request element
// without last gives no result. A request decision for a process outside the
// active range is made at dispatch, one that fails the need or availability
// check in the check state. One that passes runs the safety walk, at most P
// passes over P active processes, and rolls back when a pass makes no
// progress. Any item with a result also holds in its final state while the
// previous result is still stalled in the output register. The walk cost is
// set by the per-process row RAM: one row {claim, allocation, need} is read
// per process visit, with a registered read, and all resources are compared
// in parallel on that row. Rows come up as zero after reset through one valid
// bit per process, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module bankers_deadlock_avoidance
  import bda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_process,
  input  logic [2:0]  in_resource,
  input  logic [7:0]  in_amount,
  input  logic        in_last,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_process_echo,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFG_P_W-1:0] act_p_r;
  logic [CFG_R_W-1:0] act_r_r;
  logic [PCNT_W-1:0]  np;
  logic [RCNT_W-1:0]  nr;
  logic               cfg_wr;
  bda_cmd_t           cmd;
  bda_sts_t           sts;

  // Register file: active process count at 0x0, resource count at 0x4.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_p_r <= CFG_P_W'(PROCESS_COUNT);
      act_r_r <= CFG_R_W'(RESOURCE_COUNT);
    end else if (cfg_wr) begin
      if (paddr[2] == CFG_IDX_PROC) act_p_r <= pwdata[CFG_P_W-1:0];
      if (paddr[2] == CFG_IDX_RES)  act_r_r <= pwdata[CFG_R_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_RES) ? 32'(act_r_r) : 32'(act_p_r);

  // Out-of-range counts clamp into 1..max.
  always_comb begin
    if (act_p_r == '0)                          np = PCNT_W'(1);
    else if (32'(act_p_r) > PROCESS_COUNT)      np = PCNT_W'(PROCESS_COUNT);
    else                                        np = PCNT_W'(act_p_r);
    if (act_r_r == '0)                          nr = RCNT_W'(1);
    else if (32'(act_r_r) > RESOURCE_COUNT)     nr = RCNT_W'(RESOURCE_COUNT);
    else                                        nr = RCNT_W'(act_r_r);
  end

  bda_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  bda_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_operation),
    .in_process       (in_process),
    .in_resource      (in_resource),
    .in_amount        (in_amount),
    .np               (np),
    .nr               (nr),
    .cmd              (cmd),
    .sts              (sts),
    .out_status       (out_status),
    .out_process_echo (out_process_echo)
  );

endmodule

@@ rtl/bda_ram.sv @@
// ----------------------------------------------------------------------------
// bda_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bda_ctrl.sv @@
// ----------------------------------------------------------------------------
// bda_ctrl
// Sequencer: item dispatch, request checks, safety walk, result handoff.
// ----------------------------------------------------------------------------
module bda_ctrl
  import bda_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output bda_cmd_t   cmd,
  input  bda_sts_t   sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_CLAIM = 4'd2;
  localparam logic [3:0] S_REL   = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_WINIT = 4'd5;
  localparam logic [3:0] S_WRD   = 4'd6;
  localparam logic [3:0] S_WEV   = 4'd7;
  localparam logic [3:0] S_RBRD  = 4'd8;
  localparam logic [3:0] S_RBWR  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.st    = ST_DONE;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.cap = 1'b1;
          if (!(in_operation == OP_REQUEST && !in_last)) begin
            state_nxt = S_DISP;
          end
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_LOAD_AVAIL: state_nxt = S_FIN;
          OP_LOAD_CLAIM: state_nxt = sts.proc_ok ? S_CLAIM : S_FIN;
          OP_RELEASE:    state_nxt = sts.proc_ok ? S_REL : S_FIN;
          OP_REQUEST: begin
            if (sts.proc_ok) begin
              state_nxt = S_CHECK;
            end else begin
              cmd.set_st   = 1'b1;
              cmd.st       = ST_NEED;
              cmd.clr_pend = 1'b1;
              state_nxt    = S_FIN;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_CLAIM: begin
        cmd.wr_claim = 1'b1;
        state_nxt    = S_FIN;
      end
      S_REL: begin
        cmd.wr_release = 1'b1;
        state_nxt      = S_FIN;
      end
      S_CHECK: begin
        if (sts.chk_fail) begin
          cmd.set_st   = 1'b1;
          cmd.st       = sts.chk_st;
          cmd.clr_pend = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          cmd.wr_grant = 1'b1;
          state_nxt    = S_WINIT;
        end
      end
      S_WINIT: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_WRD;
      end
      S_WRD: begin
        cmd.sel_walk = 1'b1;
        state_nxt    = S_WEV;
      end
      S_WEV: begin
        cmd.walk_eval = 1'b1;
        state_nxt     = S_WRD;
        if (sts.walk_last) begin
          if (sts.all_done) begin
            cmd.set_st   = 1'b1;
            cmd.st       = ST_GRANTED;
            cmd.clr_pend = 1'b1;
            state_nxt    = S_FIN;
          end else if (!sts.progress) begin
            state_nxt = S_RBRD;
          end
        end
      end
      S_RBRD: begin
        state_nxt = S_RBWR;
      end
      S_RBWR: begin
        cmd.wr_rollback = 1'b1;
        cmd.set_st      = 1'b1;
        cmd.st          = ST_UNSAFE;
        cmd.clr_pend    = 1'b1;
        state_nxt       = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/bda_dp.sv @@
// ----------------------------------------------------------------------------
// bda_dp
// Datapath: available/pending/work vectors, per-process row RAM, checks.
// ----------------------------------------------------------------------------
module bda_dp
  import bda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_operation,
  input  logic [3:0]        in_process,
  input  logic [2:0]        in_resource,
  input  logic [7:0]        in_amount,
  input  logic [PCNT_W-1:0] np,
  input  logic [RCNT_W-1:0] nr,
  input  bda_cmd_t          cmd,
  output bda_sts_t          sts,
  output logic [2:0]        out_status,
  output logic [3:0]        out_process_echo
);

  function automatic logic [UNIT_WIDTH-1:0] sat_add(input logic [UNIT_WIDTH-1:0] a,
                                                     input logic [UNIT_WIDTH-1:0] b);
    logic [UNIT_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[UNIT_WIDTH] ? {UNIT_WIDTH{1'b1}} : s[UNIT_WIDTH-1:0];
  endfunction

  logic [1:0]            op_r;
  logic [PROC_W-1:0]     proc_r;
  logic [RES_W-1:0]      res_r;
  logic [UNIT_WIDTH-1:0] amt_r;
  logic [UNIT_WIDTH-1:0] avail_r [RESOURCE_COUNT];
  logic [UNIT_WIDTH-1:0] pend_r  [RESOURCE_COUNT];
  logic [UNIT_WIDTH-1:0] work_r  [RESOURCE_COUNT];
  logic [PROCESS_COUNT-1:0] fin_r;
  logic [PCNT_W-1:0]     done_r;
  logic                  prog_r;
  logic [PROC_W-1:0]     walk_p_r;
  logic [PROCESS_COUNT-1:0] row_vld_r;
  logic                  vld_q_r;
  logic [2:0]            st_r;
  logic [2:0]            out_status_r;
  logic [PROC_W-1:0]     out_proc_r;

  logic [PROC_W-1:0]     raddr;
  logic [RAM_W-1:0]      rdata, row, wdata;
  logic                  we;
  logic [UNIT_WIDTH-1:0] max_v [RESOURCE_COUNT];
  logic [UNIT_WIDTH-1:0] alc_v [RESOURCE_COUNT];
  logic [UNIT_WIDTH-1:0] need_v [RESOURCE_COUNT];
  logic [RESOURCE_COUNT-1:0] act, bad_need, bad_av, fit_j;
  logic                  fit;
  logic [2:0]            chk_st;
  logic [PCNT_W-1:0]     done_sum;

  assign raddr = cmd.sel_walk ? walk_p_r : proc_r;
  assign we    = cmd.wr_claim | cmd.wr_grant | cmd.wr_rollback | cmd.wr_release;

  bda_ram #(.WIDTH(RAM_W), .DEPTH(PROCESS_COUNT)) u_rows (
    .clk   (clk),
    .we    (we),
    .waddr (proc_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // rows never written read as zero
  assign row = vld_q_r ? rdata : '0;

  always_comb begin
    for (int j = 0; j < RESOURCE_COUNT; j++) begin
      max_v[j]  = row[2*ROW_W + j*UNIT_WIDTH +: UNIT_WIDTH];
      alc_v[j]  = row[ROW_W + j*UNIT_WIDTH +: UNIT_WIDTH];
      need_v[j] = row[j*UNIT_WIDTH +: UNIT_WIDTH];
      act[j]    = (RCNT_W'(j) < nr);
      bad_need[j] = act[j] && (pend_r[j] > need_v[j]);
      bad_av[j]   = act[j] && (pend_r[j] > avail_r[j]);
      fit_j[j]    = !act[j] || (need_v[j] <= work_r[j]);
    end
    fit    = !fin_r[walk_p_r] && (&fit_j);
    chk_st = ST_NEED;
    for (int j = RESOURCE_COUNT - 1; j >= 0; j--) begin
      if (bad_need[j] || bad_av[j]) begin
        chk_st = bad_need[j] ? ST_NEED : ST_UNAVAIL;
      end
    end
  end

  // row write data
  always_comb begin
    logic [UNIT_WIDTH-1:0] m, a, n;
    wdata = row;
    for (int j = 0; j < RESOURCE_COUNT; j++) begin
      m = max_v[j];
      a = alc_v[j];
      n = need_v[j];
      if (cmd.wr_claim && RES_W'(j) == res_r) begin
        m = amt_r;
        a = '0;
        n = amt_r;
      end
      if (act[j]) begin
        if (cmd.wr_grant) begin
          a = alc_v[j] + pend_r[j];
          n = need_v[j] - pend_r[j];
        end
        if (cmd.wr_rollback) begin
          a = alc_v[j] - pend_r[j];
          n = need_v[j] + pend_r[j];
        end
        if (cmd.wr_release) begin
          a = '0;
          n = max_v[j];
        end
      end
      wdata[2*ROW_W + j*UNIT_WIDTH +: UNIT_WIDTH] = m;
      wdata[ROW_W + j*UNIT_WIDTH +: UNIT_WIDTH]   = a;
      wdata[j*UNIT_WIDTH +: UNIT_WIDTH]           = n;
    end
  end

  assign done_sum = done_r + PCNT_W'(fit);

  always_comb begin
    sts           = '0;
    sts.op        = op_r;
    sts.proc_ok   = ({1'b0, proc_r} < np);
    sts.chk_fail  = |(bad_need | bad_av);
    sts.chk_st    = chk_st;
    sts.walk_last = ({1'b0, walk_p_r} == np - PCNT_W'(1));
    sts.all_done  = (done_sum == np);
    sts.progress  = prog_r | fit;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      fin_r     <= '0;
      done_r    <= '0;
      prog_r    <= 1'b0;
      walk_p_r  <= '0;
      vld_q_r   <= 1'b0;
      for (int j = 0; j < RESOURCE_COUNT; j++) begin
        avail_r[j] <= '0;
        pend_r[j]  <= '0;
      end
    end else begin
      vld_q_r <= row_vld_r[raddr];
      if (we) begin
        row_vld_r[proc_r] <= 1'b1;
      end
      if (cmd.cap && in_operation == OP_LOAD_AVAIL) begin
        avail_r[in_resource] <= in_amount[UNIT_WIDTH-1:0];
      end
      if (cmd.cap && in_operation == OP_REQUEST) begin
        pend_r[in_resource] <= in_amount[UNIT_WIDTH-1:0];
      end
      for (int j = 0; j < RESOURCE_COUNT; j++) begin
        if (act[j]) begin
          if (cmd.wr_grant)    avail_r[j] <= avail_r[j] - pend_r[j];
          if (cmd.wr_rollback) avail_r[j] <= avail_r[j] + pend_r[j];
          if (cmd.wr_release)  avail_r[j] <= sat_add(avail_r[j], alc_v[j]);
        end
        if (cmd.clr_pend) pend_r[j] <= '0;
      end
      if (cmd.walk_init) begin
        fin_r    <= '0;
        done_r   <= '0;
        prog_r   <= 1'b0;
        walk_p_r <= '0;
      end
      if (cmd.walk_eval) begin
        if (fit) begin
          fin_r[walk_p_r] <= 1'b1;
        end
        done_r <= done_sum;
        if (sts.walk_last) begin
          walk_p_r <= '0;
          prog_r   <= 1'b0;
        end else begin
          walk_p_r <= walk_p_r + PROC_W'(1);
          prog_r   <= prog_r | fit;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r   <= in_operation;
      proc_r <= in_process;
      res_r  <= in_resource;
      amt_r  <= in_amount[UNIT_WIDTH-1:0];
      st_r   <= ST_DONE;
    end else if (cmd.set_st) begin
      st_r <= cmd.st;
    end
    for (int j = 0; j < RESOURCE_COUNT; j++) begin
      if (cmd.walk_init) begin
        work_r[j] <= avail_r[j];
      end else if (cmd.walk_eval && fit && act[j]) begin
        work_r[j] <= sat_add(work_r[j], alc_v[j]);
      end
    end
    if (cmd.load_out) begin
      out_status_r <= st_r;
      out_proc_r   <= proc_r;
    end
  end

  assign out_status       = out_status_r;
  assign out_process_echo = out_proc_r;

endmodule

@@ rtl/bda_checker.sv @@
// ----------------------------------------------------------------------------
// bda_checker
// Port-level assertions for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bankers_deadlock_avoidance_defines.svh"

module bda_checker
  import bda_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_operation,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status
);

  `BDA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status), "result dropped or changed while stalled")
  `BDA_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, out_status <= ST_DONE, "result status out of range")
  `BDA_ASSERT_NEXT(a_busy_after_item, clk, rst_n, in_valid && !in_stall && (in_operation != OP_REQUEST || in_last), in_stall, "item producing a result not held busy")
  `BDA_ASSERT_NEXT(a_elem_no_stall, clk, rst_n, in_valid && !in_stall && in_operation == OP_REQUEST && !in_last, !in_stall, "request element stalled next item")

endmodule

bind bankers_deadlock_avoidance bda_checker u_bda_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_operation (in_operation),
  .in_last      (in_last),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_status   (out_status)
);

@@ dv/bda_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banker's allocator checker
// Watches the register port and both item channels, keeps its own copy of the
// allocator state, predicts each decision and compares it with the results.
// ----------------------------------------------------------------------------
module bda_tb_checker
  import bda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_process,
  input  logic [2:0]  in_resource,
  input  logic [7:0]  in_amount,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [3:0]  out_process_echo,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          error_count,
  output int          awaited_count
);

  typedef logic [UNIT_WIDTH-1:0] units_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [PROC_W-1:0] proc;
  } decision_t;

  units_t avail_units [RESOURCE_COUNT];
  units_t claim_units [PROCESS_COUNT][RESOURCE_COUNT];
  units_t held_units  [PROCESS_COUNT][RESOURCE_COUNT];
  units_t need_units  [PROCESS_COUNT][RESOURCE_COUNT];
  units_t pend_units  [RESOURCE_COUNT];
  logic [CFG_P_W-1:0] proc_reg;
  logic [CFG_R_W-1:0] res_reg;
  decision_t decision_q[$];

  function automatic int live_procs();
    int p;
    p = proc_reg;
    if (p < 1) p = 1;
    if (p > PROCESS_COUNT) p = PROCESS_COUNT;
    return p;
  endfunction

  function automatic int live_res();
    int r;
    r = res_reg;
    if (r < 1) r = 1;
    if (r > RESOURCE_COUNT) r = RESOURCE_COUNT;
    return r;
  endfunction

  function automatic units_t sat_sum(units_t a, units_t b);
    logic [UNIT_WIDTH:0] s;
    s = a + b;
    return s[UNIT_WIDTH] ? '1 : s[UNIT_WIDTH-1:0];
  endfunction

  // every active process must be able to finish in some order
  function automatic logic system_safe(int np, int nr);
    units_t work [RESOURCE_COUNT];
    logic   fin  [PROCESS_COUNT];
    int     done;
    logic   moved;
    logic   fits;
    done = 0;
    for (int j = 0; j < nr; j++) work[j] = avail_units[j];
    for (int p = 0; p < PROCESS_COUNT; p++) fin[p] = 1'b0;
    while (done < np) begin
      moved = 1'b0;
      for (int p = 0; p < np; p++) begin
        if (!fin[p]) begin
          fits = 1'b1;
          for (int j = 0; j < nr; j++)
            if (need_units[p][j] > work[j]) fits = 1'b0;
          if (fits) begin
            for (int j = 0; j < nr; j++) work[j] = sat_sum(work[j], held_units[p][j]);
            fin[p] = 1'b1;
            moved = 1'b1;
            done++;
          end
        end
      end
      if (!moved) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [2:0] judge_request(int proc);
    int np, nr;
    np = live_procs();
    nr = live_res();
    if (proc >= np) return ST_NEED;
    // first failing resource decides, need checked before availability
    for (int j = 0; j < nr; j++) begin
      if (pend_units[j] > need_units[proc][j]) return ST_NEED;
      if (pend_units[j] > avail_units[j]) return ST_UNAVAIL;
    end
    for (int j = 0; j < nr; j++) begin
      avail_units[j] -= pend_units[j];
      held_units[proc][j] += pend_units[j];
      need_units[proc][j] -= pend_units[j];
    end
    if (system_safe(np, nr)) return ST_GRANTED;
    for (int j = 0; j < nr; j++) begin
      avail_units[j] += pend_units[j];
      held_units[proc][j] -= pend_units[j];
      need_units[proc][j] += pend_units[j];
    end
    return ST_UNSAFE;
  endfunction

  task automatic apply_item();
    decision_t d;
    logic proc_ok;
    proc_ok = in_process < live_procs();
    d.proc = in_process;
    d.status = ST_DONE;
    case (in_operation)
      OP_LOAD_AVAIL: avail_units[in_resource] = in_amount;
      OP_LOAD_CLAIM: begin
        if (proc_ok) begin
          claim_units[in_process][in_resource] = in_amount;
          held_units[in_process][in_resource] = '0;
          need_units[in_process][in_resource] = in_amount;
        end
      end
      OP_REQUEST: begin
        pend_units[in_resource] = in_amount;
        if (!in_last) return;
        d.status = judge_request(in_process);
        for (int j = 0; j < RESOURCE_COUNT; j++) pend_units[j] = '0;
      end
      default: begin
        if (proc_ok) begin
          for (int j = 0; j < live_res(); j++) begin
            avail_units[j] = sat_sum(avail_units[j], held_units[in_process][j]);
            held_units[in_process][j] = '0;
            need_units[in_process][j] = claim_units[in_process][j];
          end
        end
      end
    endcase
    decision_q.push_back(d);
  endtask

  always @(posedge clk) begin
    decision_t want;
    if (!rst_n) begin
      proc_reg = 5'd16;
      res_reg = 4'd8;
      for (int j = 0; j < RESOURCE_COUNT; j++) begin
        avail_units[j] = '0;
        pend_units[j] = '0;
        for (int p = 0; p < PROCESS_COUNT; p++) begin
          claim_units[p][j] = '0;
          held_units[p][j] = '0;
          need_units[p][j] = '0;
        end
      end
      decision_q.delete();
      error_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == CFG_IDX_PROC) proc_reg = pwdata[CFG_P_W-1:0];
        else res_reg = pwdata[CFG_R_W-1:0];
      end
      if (in_valid && !in_stall) apply_item();
      if (out_valid && !out_stall) begin
        if (decision_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d process %0d",
                   $time, out_status, out_process_echo);
          error_count++;
        end else begin
          want = decision_q.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d (process %0d)",
                     $time, want.status, out_status, want.proc);
            error_count++;
          end
          if (out_process_echo !== want.proc) begin
            $display("%0t: process echo mismatch: expected %0d, actual %0d",
                     $time, want.proc, out_process_echo);
            error_count++;
          end
        end
      end
    end
    awaited_count = decision_q.size();
  end

endmodule

@@ dv/bankers_deadlock_avoidance_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banker's allocator testbench
// Drives loads, claims, multi-item requests and releases under several
// register settings with random gaps and output stalls; the checker predicts
// every decision and this top reports the verdict.
// ----------------------------------------------------------------------------
module bankers_deadlock_avoidance_tb;
  import bda_pkg::*;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int ITEM_TARGET  = 1050;
  // drain margin that covers a full safety walk at 16 processes
  localparam int SETTLE_CYCLES = 700;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [3:0]  in_process;
  logic [2:0]  in_resource;
  logic [7:0]  in_amount;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [3:0]  out_process_echo;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int error_count;
  int awaited_count;
  int item_count;
  int cycle_count = 0;
  int tb_procs;      // clamped settings, mirrored for building requests
  int tb_res;
  logic no_gaps;     // stretches where neither side idles

  bankers_deadlock_avoidance uut (.*);

  bda_tb_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver stall: mostly short, sometimes long, none during gapless stretches
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n || no_gaps) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      automatic int r = $urandom_range(0, 99);
      if (r < 55) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(0, 4);
      end else if (r < 93) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(10, 60);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // one item; fields change only once the previous item is taken
  task automatic send_item(logic [1:0] op, logic [3:0] proc, logic [2:0] res,
                           logic [7:0] amt, logic last);
    int gap;
    logic taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_process <= proc;
    in_resource <= res;
    in_amount <= amt;
    in_last <= last;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    item_count++;
  endtask

  // drain: no result outstanding, then room for a walk that gives none
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_sizes(int procs, int res);
    write_reg(CFG_IDX_PROC, procs);
    write_reg(CFG_IDX_RES, res);
    tb_procs = (procs < 1) ? 1 : (procs > PROCESS_COUNT) ? PROCESS_COUNT : procs;
    tb_res = (res < 1) ? 1 : (res > RESOURCE_COUNT) ? RESOURCE_COUNT : res;
  endtask

  // whole request over the active resources, small amounts mostly
  task automatic send_request(logic [3:0] proc);
    logic [7:0] amt;
    for (int j = 0; j < tb_res; j++) begin
      amt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 3));
      send_item(OP_REQUEST, proc, 3'(j), amt, j == tb_res - 1);
    end
  endtask

  function automatic logic [3:0] pick_proc();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, tb_procs - 1));
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send_item(OP_LOAD_AVAIL, 4'($urandom), 3'($urandom_range(0, 7)),
                ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30)),
                1'($urandom));
    end else if (r < 25) begin
      send_item(OP_LOAD_CLAIM, pick_proc(), 3'($urandom_range(0, 7)),
                ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
                1'($urandom));
    end else if (r < 35) begin
      send_item(OP_RELEASE, pick_proc(), 3'($urandom), 8'($urandom), 1'($urandom));
    end else if (r < 90) begin
      send_request(pick_proc());
    end else begin
      // noise: stray elements with any index and last bit
      send_item(2'($urandom), 4'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_LOAD_AVAIL;
    in_process = '0;
    in_resource = '0;
    in_amount = '0;
    in_last = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    no_gaps = 1'b0;
    item_count = 0;
    tb_procs = PROCESS_COUNT;
    tb_res = RESOURCE_COUNT;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: small system, extremes, every outcome
    set_sizes(3, 2);
    send_item(OP_LOAD_AVAIL, 4'd0, 3'd0, 8'd5, 1'b0);
    send_item(OP_LOAD_AVAIL, 4'd0, 3'd1, 8'd255, 1'b1);
    send_item(OP_LOAD_AVAIL, 4'd0, 3'd7, 8'd9, 1'b0);       // beyond active resources
    send_item(OP_LOAD_CLAIM, 4'd0, 3'd0, 8'd4, 1'b0);
    send_item(OP_LOAD_CLAIM, 4'd0, 3'd1, 8'd2, 1'b0);
    send_item(OP_LOAD_CLAIM, 4'd1, 3'd0, 8'd3, 1'b0);
    send_item(OP_LOAD_CLAIM, 4'd15, 3'd0, 8'd1, 1'b0);      // process out of range
    send_item(OP_REQUEST, 4'd0, 3'd0, 8'd5, 1'b0);          // over need
    send_item(OP_REQUEST, 4'd0, 3'd1, 8'd0, 1'b1);
    send_item(OP_REQUEST, 4'd0, 3'd0, 8'd4, 1'b0);          // granted
    send_item(OP_REQUEST, 4'd0, 3'd1, 8'd2, 1'b1);
    send_item(OP_REQUEST, 4'd1, 3'd0, 8'd2, 1'b0);          // unavailable
    send_item(OP_REQUEST, 4'd1, 3'd1, 8'd0, 1'b1);
    send_item(OP_RELEASE, 4'd0, 3'd0, 8'd0, 1'b0);          // release, resource 1 back to 255
    send_item(OP_LOAD_CLAIM, 4'd2, 3'd0, 8'd255, 1'b0);
    send_item(OP_REQUEST, 4'd1, 3'd0, 8'd3, 1'b0);          // leaves process 2 stuck
    send_item(OP_REQUEST, 4'd1, 3'd1, 8'd0, 1'b1);
    send_item(OP_REQUEST, 4'd9, 3'd0, 8'd0, 1'b1);          // request from idle process
    send_item(OP_RELEASE, 4'd12, 3'd7, 8'd255, 1'b1);
    send_item(OP_REQUEST, 4'd0, 3'd6, 8'd255, 1'b1);        // single-item request

    // random phases over changing sizes, the extremes included
    while (item_count < ITEM_TARGET) begin
      int pick;
      int phase_items;
      wait_idle();
      pick = $urandom_range(0, 5);
      case (pick)
        0: set_sizes(1, 1);
        1: set_sizes(16, 8);
        2: set_sizes(31, 15);
        3: set_sizes(0, 0);
        default: set_sizes($urandom_range(1, 16), $urandom_range(1, 8));
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      // fill the availability so requests can get through
      for (int j = 0; j < tb_res; j++)
        send_item(OP_LOAD_AVAIL, 4'($urandom), 3'(j), 8'($urandom_range(4, 40)), 1'($urandom));
      phase_items = 0;
      while (phase_items < 80 && item_count < ITEM_TARGET) begin
        if ($urandom_range(0, 49) == 0) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (awaited_count != 0) @(posedge clk);
        end
        random_item();
        phase_items++;
      end
      no_gaps = 1'b0;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bda_pkg.sv
rtl/bda_ram.sv
rtl/bda_ctrl.sv
rtl/bda_dp.sv
rtl/bankers_deadlock_avoidance.sv
rtl/bda_checker.sv
dv/bda_checker.sv
dv/bankers_deadlock_avoidance_tb.sv
